>>> hdl/edtq_pkg.sv
// Shared types and codes for the earliest-deadline timer queue.
package edtq_pkg;

    localparam int TASK_W   = 8;
    localparam int TIME_W   = 48;
    localparam int PERIOD_W = 32;
    localparam int COUNT_W  = 5;

    localparam logic [1:0] REQ_ADD   = 2'd0;
    localparam logic [1:0] REQ_TICK  = 2'd1;
    localparam logic [1:0] REQ_CLEAR = 2'd2;
    localparam logic [1:0] REQ_NONE  = 2'd3;

    typedef struct packed {
        logic [1:0]          req_type;
        logic [TASK_W-1:0]   task_id;
        logic [TIME_W-1:0]   due_time;
        logic [PERIOD_W-1:0] repeat_period;
        logic                is_periodic;
        logic [TIME_W-1:0]   now_time;
    } req_item_t;

    typedef struct packed {
        logic                fired_valid;
        logic [TASK_W-1:0]   fired_task;
        logic [TIME_W-1:0]   fired_time;
        logic                run_last;
        logic                add_dropped;
        logic [COUNT_W-1:0]  entry_count;
    } res_item_t;

    typedef enum logic [1:0] {
        OP_HOLD,
        OP_POP,
        OP_INSERT,
        OP_CLEAR
    } cell_op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DRAIN,
        ST_FIRE
    } state_t;

endpackage

>>> hdl/edtq_cell.sv
// One slot of a sorted shift queue: holds an entry and trades it with its neighbors.
module edtq_cell #(
    parameter int TIME_BITS = 48,
    parameter int ID_BITS   = 8
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  edtq_pkg::cell_op_t        op,
    // entry being inserted
    input  logic [ID_BITS-1:0]        new_task,
    input  logic [TIME_BITS-1:0]      new_due,
    input  logic [edtq_pkg::PERIOD_W-1:0] new_period,
    input  logic                      new_repeat,
    // left neighbor (closer to the head)
    input  logic                      gt_in,
    input  logic                      lft_used,
    input  logic [ID_BITS-1:0]        lft_task,
    input  logic [TIME_BITS-1:0]      lft_due,
    input  logic [edtq_pkg::PERIOD_W-1:0] lft_period,
    input  logic                      lft_repeat,
    // right neighbor (closer to the tail)
    input  logic                      rgt_used,
    input  logic [ID_BITS-1:0]        rgt_task,
    input  logic [TIME_BITS-1:0]      rgt_due,
    input  logic [edtq_pkg::PERIOD_W-1:0] rgt_period,
    input  logic                      rgt_repeat,
    // stored entry
    output logic                      gt_out,
    output logic                      used,
    output logic [ID_BITS-1:0]        task_id,
    output logic [TIME_BITS-1:0]      due,
    output logic [edtq_pkg::PERIOD_W-1:0] period,
    output logic                      repeat_flag
);
    import edtq_pkg::*;

    logic                used_reg, used_next;
    logic [ID_BITS-1:0]  task_reg, task_next;
    logic [TIME_BITS-1:0] due_reg, due_next;
    logic [PERIOD_W-1:0] period_reg, period_next;
    logic                repeat_reg, repeat_next;

    // an empty slot sorts after everything
    assign gt_out = !used_reg || (due_reg > new_due);

    always_comb
    begin
        used_next   = used_reg;
        task_next   = task_reg;
        due_next    = due_reg;
        period_next = period_reg;
        repeat_next = repeat_reg;
        unique case (op)
            OP_HOLD:
            begin
            end
            OP_POP:
            begin
                used_next   = rgt_used;
                task_next   = rgt_task;
                due_next    = rgt_due;
                period_next = rgt_period;
                repeat_next = rgt_repeat;
            end
            OP_INSERT:
            begin
                if (gt_in)
                begin
                    used_next   = lft_used;
                    task_next   = lft_task;
                    due_next    = lft_due;
                    period_next = lft_period;
                    repeat_next = lft_repeat;
                end
                else if (gt_out)
                begin
                    used_next   = 1'b1;
                    task_next   = new_task;
                    due_next    = new_due;
                    period_next = new_period;
                    repeat_next = new_repeat;
                end
            end
            OP_CLEAR:
            begin
                used_next = 1'b0;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg <= 1'b0;
        end
        else
        begin
            used_reg <= used_next;
        end
    end

    always_ff @(posedge clk)
    begin
        task_reg   <= task_next;
        due_reg    <= due_next;
        period_reg <= period_next;
        repeat_reg <= repeat_next;
    end

    assign used        = used_reg;
    assign task_id     = task_reg;
    assign due         = due_reg;
    assign period      = period_reg;
    assign repeat_flag = repeat_reg;

endmodule

>>> hdl/edtq_row.sv
// Row of queue cells kept sorted by due time; exposes the head entry.
module edtq_row #(
    parameter int DEPTH     = 16,
    parameter int TIME_BITS = 48,
    parameter int ID_BITS   = 8
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  edtq_pkg::cell_op_t            op,
    input  logic [ID_BITS-1:0]            new_task,
    input  logic [TIME_BITS-1:0]          new_due,
    input  logic [edtq_pkg::PERIOD_W-1:0] new_period,
    input  logic                          new_repeat,
    output logic                          head_used,
    output logic [ID_BITS-1:0]            head_task,
    output logic [TIME_BITS-1:0]          head_due,
    output logic [edtq_pkg::PERIOD_W-1:0] head_period,
    output logic                          head_repeat
);
    import edtq_pkg::*;

    logic                 gt_chain [DEPTH+1];
    logic                 c_used   [DEPTH];
    logic [ID_BITS-1:0]   c_task   [DEPTH];
    logic [TIME_BITS-1:0] c_due    [DEPTH];
    logic [PERIOD_W-1:0]  c_period [DEPTH];
    logic                 c_repeat [DEPTH];

    assign gt_chain[0] = 1'b0;

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic                 l_used, r_used;
        logic [ID_BITS-1:0]   l_task, r_task;
        logic [TIME_BITS-1:0] l_due, r_due;
        logic [PERIOD_W-1:0]  l_period, r_period;
        logic                 l_repeat, r_repeat;

        if (i == 0)
        begin : g_first
            assign l_used   = 1'b0;
            assign l_task   = '0;
            assign l_due    = '0;
            assign l_period = '0;
            assign l_repeat = 1'b0;
        end
        else
        begin : g_mid_l
            assign l_used   = c_used[i-1];
            assign l_task   = c_task[i-1];
            assign l_due    = c_due[i-1];
            assign l_period = c_period[i-1];
            assign l_repeat = c_repeat[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign r_used   = 1'b0;
            assign r_task   = '0;
            assign r_due    = '0;
            assign r_period = '0;
            assign r_repeat = 1'b0;
        end
        else
        begin : g_mid_r
            assign r_used   = c_used[i+1];
            assign r_task   = c_task[i+1];
            assign r_due    = c_due[i+1];
            assign r_period = c_period[i+1];
            assign r_repeat = c_repeat[i+1];
        end

        edtq_cell #(
            .TIME_BITS (TIME_BITS),
            .ID_BITS   (ID_BITS)
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .op          (op),
            .new_task    (new_task),
            .new_due     (new_due),
            .new_period  (new_period),
            .new_repeat  (new_repeat),
            .gt_in       (gt_chain[i]),
            .lft_used    (l_used),
            .lft_task    (l_task),
            .lft_due     (l_due),
            .lft_period  (l_period),
            .lft_repeat  (l_repeat),
            .rgt_used    (r_used),
            .rgt_task    (r_task),
            .rgt_due     (r_due),
            .rgt_period  (r_period),
            .rgt_repeat  (r_repeat),
            .gt_out      (gt_chain[i+1]),
            .used        (c_used[i]),
            .task_id     (c_task[i]),
            .due         (c_due[i]),
            .period      (c_period[i]),
            .repeat_flag (c_repeat[i])
        );
    end

    assign head_used   = c_used[0];
    assign head_task   = c_task[0];
    assign head_due    = c_due[0];
    assign head_period = c_period[0];
    assign head_repeat = c_repeat[0];

endmodule

>>> hdl/earliest_deadline_timer_queue.sv
// Top level: earliest-deadline timer queue with periodic re-arming.
// An add, clear, held tick or tick with nothing due gives its single result in
// the cycle after it is accepted; one request per cycle then, while results are taken.
// A tick that fires k entries first drains them, one head pop per cycle from
// the queue row into staging, then gives one result per cycle as out_ready allows.
// Reset clears the slot used bits, entry count, run_enable and all handshakes.
module earliest_deadline_timer_queue #(
    parameter int QUEUE_DEPTH = 16,
    parameter int TIME_BITS   = 48,
    parameter int ID_BITS     = 8
) (
    input  logic                  clk,
    input  logic                  rst_n,
    // configuration write channel: run_enable
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic                  cfg_data,
    // request channel
    input  logic                  in_valid,
    output logic                  in_ready,
    input  edtq_pkg::req_item_t   in_data,
    // result channel
    output logic                  out_valid,
    input  logic                  out_ready,
    output edtq_pkg::res_item_t   out_data
);
    import edtq_pkg::*;

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int SUM_W = ((TIME_BITS > PERIOD_W) ? TIME_BITS : PERIOD_W) + 1;

    state_t state_reg, state_next;

    logic                 run_enable_reg;
    logic [CNT_W-1:0]     held_reg, held_next;
    logic [CNT_W-1:0]     stage_cnt_reg, stage_cnt_next;
    logic [CNT_W-1:0]     per_cnt_reg, per_cnt_next;
    logic [CNT_W-1:0]     fin_reg, fin_next;
    logic [TIME_BITS-1:0] now_reg, now_next;
    res_item_t            out_reg, out_next;
    logic                 out_valid_reg, out_valid_next;

    // main queue row
    cell_op_t             m_op;
    logic [ID_BITS-1:0]   m_new_task;
    logic [TIME_BITS-1:0] m_new_due;
    logic [PERIOD_W-1:0]  m_new_period;
    logic                 m_new_repeat;
    logic                 m_head_used;
    logic [ID_BITS-1:0]   m_head_task;
    logic [TIME_BITS-1:0] m_head_due;
    logic [PERIOD_W-1:0]  m_head_period;
    logic                 m_head_repeat;

    // staging row: entries fired by the current tick, in firing order
    cell_op_t             s_op;
    logic                 s_head_used;
    logic [ID_BITS-1:0]   s_head_task;
    logic [TIME_BITS-1:0] s_head_due;
    logic [PERIOD_W-1:0]  s_head_period;
    logic                 s_head_repeat;

    logic                 out_free;
    logic                 fire_go;
    logic                 in_fire;
    logic [TIME_BITS-1:0] in_now;
    logic                 tick_fires;
    logic                 drain_go;
    logic [SUM_W-1:0]     rearm_sum;
    logic [TIME_BITS-1:0] rearm_due;

    // The output register frees up when empty or being taken this cycle.
    assign out_free  = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == ST_IDLE) && out_free;
    assign in_fire   = in_valid && in_ready;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // Emit the staged head once the output register can take it.
    assign fire_go = out_free && s_head_used;

    assign in_now = TIME_BITS'(in_data.now_time);

    // A tick fires when enabled and the sorted head is strictly overdue.
    assign tick_fires = (in_data.req_type == REQ_TICK) && run_enable_reg &&
                        m_head_used && (m_head_due < in_now);

    // While draining, keep popping as long as the head is still overdue.
    assign drain_go = m_head_used && (m_head_due < now_reg);

    // Re-arm time saturates at the all-ones time.
    assign rearm_sum = SUM_W'(s_head_due) + SUM_W'(s_head_period);
    assign rearm_due = (rearm_sum[SUM_W-1:TIME_BITS] != '0) ? '1
                                                           : rearm_sum[TIME_BITS-1:0];

    edtq_row #(
        .DEPTH     (QUEUE_DEPTH),
        .TIME_BITS (TIME_BITS),
        .ID_BITS   (ID_BITS)
    ) u_main (
        .clk         (clk),
        .rst_n       (rst_n),
        .op          (m_op),
        .new_task    (m_new_task),
        .new_due     (m_new_due),
        .new_period  (m_new_period),
        .new_repeat  (m_new_repeat),
        .head_used   (m_head_used),
        .head_task   (m_head_task),
        .head_due    (m_head_due),
        .head_period (m_head_period),
        .head_repeat (m_head_repeat)
    );

    // Fired entries arrive in nondecreasing due order, so a sorted insert
    // appends them at the tail.
    edtq_row #(
        .DEPTH     (QUEUE_DEPTH),
        .TIME_BITS (TIME_BITS),
        .ID_BITS   (ID_BITS)
    ) u_stage (
        .clk         (clk),
        .rst_n       (rst_n),
        .op          (s_op),
        .new_task    (m_head_task),
        .new_due     (m_head_due),
        .new_period  (m_head_period),
        .new_repeat  (m_head_repeat),
        .head_used   (s_head_used),
        .head_task   (s_head_task),
        .head_due    (s_head_due),
        .head_period (s_head_period),
        .head_repeat (s_head_repeat)
    );

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire && tick_fires)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!drain_go)
                begin
                    state_next = ST_FIRE;
                end
            end
            ST_FIRE:
            begin
                if (fire_go && (stage_cnt_reg == CNT_W'(1)))
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Datapath control and register updates.
    always_comb
    begin
        m_op           = OP_HOLD;
        s_op           = OP_HOLD;
        m_new_task     = ID_BITS'(in_data.task_id);
        m_new_due      = TIME_BITS'(in_data.due_time);
        m_new_period   = in_data.repeat_period;
        m_new_repeat   = in_data.is_periodic;
        held_next      = held_reg;
        stage_cnt_next = stage_cnt_reg;
        per_cnt_next   = per_cnt_reg;
        fin_next       = fin_reg;
        now_next       = now_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !out_ready;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    out_next             = '0;
                    out_next.run_last    = 1'b1;
                    out_valid_next       = 1'b1;
                    unique case (in_data.req_type)
                        REQ_ADD:
                        begin
                            if (held_reg == CNT_W'(QUEUE_DEPTH))
                            begin
                                out_next.add_dropped = 1'b1;
                            end
                            else
                            begin
                                m_op      = OP_INSERT;
                                held_next = held_reg + CNT_W'(1);
                            end
                        end
                        REQ_CLEAR:
                        begin
                            m_op      = OP_CLEAR;
                            held_next = '0;
                        end
                        REQ_TICK:
                        begin
                            if (tick_fires)
                            begin
                                // results follow once the drain settles the count
                                out_valid_next = out_valid_reg && !out_ready;
                                out_next       = out_reg;
                                now_next       = in_now;
                                stage_cnt_next = '0;
                                per_cnt_next   = '0;
                            end
                        end
                        REQ_NONE:
                        begin
                        end
                        default:
                        begin
                        end
                    endcase
                    if (!tick_fires || (in_data.req_type != REQ_TICK))
                    begin
                        out_next.entry_count = COUNT_W'(held_next);
                    end
                end
            end
            ST_DRAIN:
            begin
                if (drain_go)
                begin
                    // move the overdue head into staging
                    m_op           = OP_POP;
                    s_op           = OP_INSERT;
                    held_next      = held_reg - CNT_W'(1);
                    stage_cnt_next = stage_cnt_reg + CNT_W'(1);
                    per_cnt_next   = per_cnt_reg + CNT_W'(m_head_repeat);
                end
                else
                begin
                    fin_next = held_reg + per_cnt_reg;
                end
            end
            ST_FIRE:
            begin
                if (fire_go)
                begin
                    out_next.fired_valid = 1'b1;
                    out_next.fired_task  = TASK_W'(s_head_task);
                    out_next.fired_time  = TIME_W'(s_head_due);
                    out_next.run_last    = (stage_cnt_reg == CNT_W'(1));
                    out_next.add_dropped = 1'b0;
                    out_next.entry_count = COUNT_W'(fin_reg);
                    out_valid_next       = 1'b1;
                    s_op                 = OP_POP;
                    stage_cnt_next       = stage_cnt_reg - CNT_W'(1);
                    if (s_head_repeat)
                    begin
                        // re-arm as a fresh insertion
                        m_op         = OP_INSERT;
                        m_new_task   = s_head_task;
                        m_new_due    = rearm_due;
                        m_new_period = s_head_period;
                        m_new_repeat = 1'b1;
                        held_next    = held_reg + CNT_W'(1);
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            run_enable_reg <= 1'b0;
            held_reg       <= '0;
            stage_cnt_reg  <= '0;
            per_cnt_reg    <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            held_reg      <= held_next;
            stage_cnt_reg <= stage_cnt_next;
            per_cnt_reg   <= per_cnt_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                run_enable_reg <= cfg_data;
            end
        end
    end

    // payload registers carry no reset
    always_ff @(posedge clk)
    begin
        fin_reg <= fin_next;
        now_reg <= now_next;
        out_reg <= out_next;
    end

endmodule
